FILE: rtl/bms_pkg.sv
// Package for the buzzer melody sequencer: state and request codes, note tables
// and the pitch and length decode functions. No dependencies.
package bms_pkg;

  // Note store depth, a power of two; store addresses wrap modulo the depth.
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  // Width used to form store addresses before they wrap (covers depths up to 8192).
  localparam int ADDR_EXT_W  = 13;

  localparam int PERIOD_W = 20;
  localparam int DIV_CW   = $clog2(PERIOD_W);
  localparam logic [PERIOD_W-1:0] TICK_HZ = PERIOD_W'(1000000);

  localparam int US_W  = 22;
  localparam int HZ_W  = 11;
  localparam logic [US_W-1:0] MIN_NOTE_US = US_W'(1000);

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_START = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_STOP  = 3'd3,
    REQ_TONE  = 3'd4
  } bms_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_FETCH,
    ST_NOTE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_PUSH
  } bms_state_t;

  localparam logic [7:0] BEAT_MS [0:6] = '{8'd0, 8'd62, 8'd94, 8'd125, 8'd125, 8'd187, 8'd250};

  localparam logic [HZ_W-1:0] PITCH_HZ [0:2][0:7] = '{
    '{11'd0, 11'd261,  11'd293,  11'd329,  11'd349,  11'd391,  11'd440,  11'd493},
    '{11'd0, 11'd523,  11'd587,  11'd659,  11'd698,  11'd783,  11'd880,  11'd987},
    '{11'd0, 11'd1046, 11'd1174, 11'd1318, 11'd1396, 11'd1567, 11'd1760, 11'd1975}
  };

  // Pitch code to frequency; codes outside the three octaves or tones 8 and 9 are silent.
  function automatic logic [HZ_W-1:0] pitch_to_hz(input logic [7:0] code);
    logic [HZ_W-1:0] hz;
    logic [7:0]      tone;
    hz   = '0;
    tone = '0;
    for (int oct = 0; oct < 3; oct++) begin
      if (code >= 8'(10 * oct) && code < 8'(10 * oct + 10)) begin
        tone = code - 8'(10 * oct);
        if (tone < 8'd8) begin
          hz = PITCH_HZ[oct][tone[2:0]];
        end
      end
    end
    return hz;
  endfunction

  // Length code to microseconds; an empty length becomes the minimum note.
  function automatic logic [US_W-1:0] length_to_us(input logic [7:0] code);
    logic [US_W-1:0] us;
    logic [7:0]      loops;
    us    = '0;
    loops = '0;
    for (int b = 0; b < 7; b++) begin
      if (code >= 8'(10 * b) && code < 8'(10 * b + 10)) begin
        loops = code - 8'(10 * b);
        us    = US_W'(BEAT_MS[b]) * US_W'(loops[3:0]) * US_W'(1000);
      end
    end
    return (us == '0) ? MIN_NOTE_US : us;
  endfunction

endpackage

FILE: rtl/buzzer_melody_sequencer.sv
// Buzzer melody sequencer top level: note store, playback sequencer and a
// bit-serial PWM period divider. Depends on bms_pkg.

// Every request (load, start, tick, stop, direct tone) produces exactly one
// result transaction that shows the PWM settings, playback flag and note
// position after the request. The block takes one request at a time: in_ready
// is high only while the sequencer is idle. A plain request passes through the
// accepting idle state, a divider load step, the bit-serial divider that turns
// the current frequency into the PWM period one quotient bit per cycle, and a
// push step that fills the output register. A start adds a note store fetch.
// A tick while playing adds a first loop test, and a store read, decode and
// loop test for every note it walks through. A tick never walks more notes
// than the melody holds, at most 511.
// A result waiting on out_ready does not hold the input: the next request is
// still taken and worked on, and only its own result waits in the last step
// until the output register has been emptied or is being emptied. The note
// store has no reset; reading a word that was never loaded gives an
// unspecified note.
module buzzer_melody_sequencer
  import bms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_req_type,
  input  logic [7:0]          in_store_addr,
  input  logic [7:0]          in_pitch_code,
  input  logic [7:0]          in_length_code,
  input  logic [8:0]          in_melody_length,
  input  logic [21:0]         in_elapsed_us,
  input  logic [19:0]         in_tone_hz,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_pwm_on,
  output logic [PERIOD_W-1:0] out_period_ticks,
  output logic [18:0]         out_compare_ticks,
  output logic                out_playing,
  output logic [8:0]          out_note_position
);

  bms_state_t state_r, state_nxt;

  // Player state.
  logic [7:0]          base_r, base_nxt;
  logic [8:0]          len_r, len_nxt;
  logic [8:0]          pos_r, pos_nxt;
  logic [US_W-1:0]     rem_r, rem_nxt;
  logic                playing_r, playing_nxt;
  logic [19:0]         hz_r, hz_nxt;

  // Per-request working registers.
  logic                tick_mode_r, tick_mode_nxt;
  logic [US_W-1:0]     dt_r, dt_nxt;

  // Serial divider: dividend shifts out MSB first, quotient bits shift in at the LSB, most significant first.
  logic [PERIOD_W-1:0] div_num_r, div_num_nxt;
  logic [PERIOD_W:0]   div_rem_r, div_rem_nxt;
  logic [PERIOD_W-1:0] div_quo_r, div_quo_nxt;
  logic [DIV_CW-1:0]   div_cnt_r, div_cnt_nxt;
  logic [PERIOD_W:0]   div_trial;
  logic [PERIOD_W-1:0] period_val;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic                out_pwm_on_r, out_pwm_on_nxt;
  logic [PERIOD_W-1:0] out_period_r, out_period_nxt;
  logic                out_playing_r, out_playing_nxt;
  logic [8:0]          out_pos_r, out_pos_nxt;

  // Note store.
  logic [15:0]           store_mem [0:STORE_DEPTH-1];
  logic [15:0]           rd_data_r;
  logic                  store_we;
  logic [ADDR_EXT_W-1:0] waddr_ext;
  logic [ADDR_EXT_W-1:0] raddr_ext;
  logic                  in_accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign store_we  = in_accept && (bms_req_t'(in_req_type) == REQ_LOAD);
  assign waddr_ext = ADDR_EXT_W'(in_store_addr);
  assign raddr_ext = ADDR_EXT_W'(base_r) + ADDR_EXT_W'(pos_r);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[waddr_ext[STORE_AW-1:0]] <= {in_pitch_code, in_length_code};
    end
    rd_data_r <= store_mem[raddr_ext[STORE_AW-1:0]];
  end

  assign div_trial  = {div_rem_r[PERIOD_W-1:0], div_num_r[PERIOD_W-1]};
  // A frequency above the tick rate still gives the shortest period of one tick.
  assign period_val = (hz_r == '0) ? '0 :
                      (div_quo_r == '0) ? PERIOD_W'(1) : div_quo_r;

  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    len_nxt         = len_r;
    pos_nxt         = pos_r;
    rem_nxt         = rem_r;
    playing_nxt     = playing_r;
    hz_nxt          = hz_r;
    tick_mode_nxt   = tick_mode_r;
    dt_nxt          = dt_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    div_quo_nxt     = div_quo_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_pwm_on_nxt  = out_pwm_on_r;
    out_period_nxt  = out_period_r;
    out_playing_nxt = out_playing_r;
    out_pos_nxt     = out_pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt     = ST_DIV_LOAD;
          tick_mode_nxt = 1'b0;
          unique case (bms_req_t'(in_req_type))
            REQ_LOAD: begin
            end
            REQ_START: begin
              if (in_melody_length == '0) begin
                playing_nxt = 1'b0;
                pos_nxt     = '0;
                rem_nxt     = '0;
                hz_nxt      = '0;
              end else begin
                base_nxt    = in_store_addr;
                len_nxt     = in_melody_length;
                pos_nxt     = '0;
                rem_nxt     = '0;
                playing_nxt = 1'b1;
                state_nxt   = ST_FETCH;
              end
            end
            REQ_TICK: begin
              if (playing_r) begin
                dt_nxt        = in_elapsed_us;
                tick_mode_nxt = 1'b1;
                state_nxt     = ST_LOOP;
              end
            end
            REQ_STOP: begin
              playing_nxt = 1'b0;
              pos_nxt     = '0;
              rem_nxt     = '0;
              hz_nxt      = '0;
            end
            REQ_TONE: begin
              playing_nxt = 1'b0;
              hz_nxt      = in_tone_hz;
            end
            default: begin
              // Unused request codes leave the state alone.
            end
          endcase
        end
      end

      ST_LOOP: begin
        if (playing_r && dt_r >= rem_r) begin
          dt_nxt = dt_r - rem_r;
          if (pos_r >= len_r) begin
            // Time ran out after the last note.
            playing_nxt = 1'b0;
            pos_nxt     = '0;
            rem_nxt     = '0;
            hz_nxt      = '0;
            state_nxt   = ST_DIV_LOAD;
          end else begin
            state_nxt = ST_FETCH;
          end
        end else begin
          if (playing_r) begin
            rem_nxt = rem_r - dt_r;
          end
          state_nxt = ST_DIV_LOAD;
        end
      end

      ST_FETCH: begin
        state_nxt = ST_NOTE;
      end

      ST_NOTE: begin
        hz_nxt    = 20'(pitch_to_hz(rd_data_r[15:8]));
        rem_nxt   = length_to_us(rd_data_r[7:0]);
        pos_nxt   = pos_r + 9'd1;
        state_nxt = tick_mode_r ? ST_LOOP : ST_DIV_LOAD;
      end

      ST_DIV_LOAD: begin
        div_num_nxt = TICK_HZ;
        div_rem_nxt = '0;
        div_quo_nxt = '0;
        div_cnt_nxt = DIV_CW'(PERIOD_W - 1);
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        div_num_nxt = {div_num_r[PERIOD_W-2:0], 1'b0};
        if (div_trial >= {1'b0, hz_r}) begin
          div_rem_nxt = div_trial - {1'b0, hz_r};
          div_quo_nxt = {div_quo_r[PERIOD_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_trial;
          div_quo_nxt = {div_quo_r[PERIOD_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - DIV_CW'(1);
        if (div_cnt_r == '0) begin
          state_nxt = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_pwm_on_nxt  = (hz_r != '0);
          out_period_nxt  = period_val;
          out_playing_nxt = playing_r;
          out_pos_nxt     = pos_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      rem_r       <= '0;
      playing_r   <= 1'b0;
      hz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      playing_r   <= playing_nxt;
      hz_r        <= hz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_mode_r   <= tick_mode_nxt;
    dt_r          <= dt_nxt;
    div_num_r     <= div_num_nxt;
    div_rem_r     <= div_rem_nxt;
    div_quo_r     <= div_quo_nxt;
    div_cnt_r     <= div_cnt_nxt;
    out_pwm_on_r  <= out_pwm_on_nxt;
    out_period_r  <= out_period_nxt;
    out_playing_r <= out_playing_nxt;
    out_pos_r     <= out_pos_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_on        = out_pwm_on_r;
  assign out_period_ticks  = out_period_r;
  assign out_compare_ticks = out_period_r[PERIOD_W-1:1];
  assign out_playing       = out_playing_r;
  assign out_note_position = out_pos_r;

endmodule

FILE: rtl/bms_checker.sv
// Port-level checker for the buzzer melody sequencer and its bind statement.
// Depends on bms_pkg and buzzer_melody_sequencer.
module bms_checker
  import bms_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_pwm_on,
  input logic [PERIOD_W-1:0] out_period_ticks,
  input logic [18:0]         out_compare_ticks
);

  // A pending result transaction is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before it was taken");

  // One request at a time: the block is busy in the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in progress");

  // The compare value is always half the period.
  a_compare_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_compare_ticks == out_period_ticks[PERIOD_W-1:1])
    else $error("compare value is not half the period");

  // The PWM is enabled exactly when it has a nonzero period.
  a_pwm_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pwm_on == (out_period_ticks != '0))
    else $error("PWM enable disagrees with the period");

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pwm_on       (out_pwm_on),
  .out_period_ticks (out_period_ticks),
  .out_compare_ticks(out_compare_ticks)
);
